// ===== src/pulse_window_sum_defines.svh =====
// Assertion macros shared by the pulse window sum RTL.
// Both take the clock clk and the synchronous reset rst from the including scope.
`ifndef PULSE_WINDOW_SUM_DEFINES_SVH
`define PULSE_WINDOW_SUM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PWS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pulse_window_sum assertion failed");
// Next-cycle implication.
`define PWS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pulse_window_sum assertion failed");
`else
`define PWS_ASSERT_IMP(label, ante, cons)
`define PWS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/pws_pkg.sv =====
`timescale 1ns / 1ps
package pws_pkg;

  localparam int MAX_GATES  = 4096;
  localparam int MAX_WINDOW = 16;

  localparam int GATE_W    = $clog2(MAX_GATES);
  localparam int SLOT_W    = $clog2(MAX_WINDOW);
  localparam int WIN_W     = 5;
  localparam int DATA_W    = 16;
  localparam int HIST_AW   = SLOT_W + GATE_W;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(4);
  localparam logic [GATE_W-1:0] LAST_GATE    = GATE_W'(MAX_GATES - 1);

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [GATE_W-1:0]        gate_t;
  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [WIN_W-1:0]         win_t;

  // Byte addresses of the configuration registers.
  typedef enum logic [PADDR_W-1:0] {
    REG_WINDOW_LENGTH = 3'd0
  } reg_addr_t;

  // Window length as used by the datapath: zero acts as one, large values clamp.
  function automatic win_t eff_window(input win_t wl);
    win_t w;
    w = wl;
    if (wl == '0) begin
      w = WIN_W'(1);
    end else if (wl > WIN_W'(MAX_WINDOW)) begin
      w = WIN_W'(MAX_WINDOW);
    end
    return w;
  endfunction

endpackage

// ===== src/pws_in_if.sv =====
`timescale 1ns / 1ps
interface pws_in_if import pws_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_in_pulse;

  modport source (output valid, output sample, output last_in_pulse, input ready);
  modport sink   (input valid, input sample, input last_in_pulse, output ready);
endinterface

// ===== src/pws_out_if.sv =====
`timescale 1ns / 1ps
interface pws_out_if import pws_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t window_sum;
  logic    last_out;

  modport source (output valid, output window_sum, output last_out, input ready);
  modport sink   (input valid, input window_sum, input last_out, output ready);
endinterface

// ===== src/pulse_window_sum.sv =====
// A request is registered into stage 1 when accepted, then into the output register
// that offers its result. Throughput: one request per cycle while the output is not
// stalled, set by the single read-modify-write of the per-gate sum memory, with
// forwarding between back-to-back requests to one gate. Reset (synchronous, active
// high) and every write of window_length start a pass that zeroes the per-gate sum
// memory; no request is taken then. The pulse history memory is not cleared.
`timescale 1ns / 1ps
module pulse_window_sum import pws_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pws_in_if.sink             din,
  pws_out_if.source          dout,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  `include "pulse_window_sum_defines.svh"

  // Configuration and run state.
  win_t  window_length;
  gate_t gate_index;
  slot_t history_count;
  slot_t oldest_slot;
  logic  clearing;
  gate_t clr_cnt;

  // Memories.
  sample_t gs_mem   [MAX_GATES];
  sample_t hist_mem [MAX_GATES * MAX_WINDOW];
  sample_t gs_rd;
  sample_t hist_rd;

  // Stage 1 (memory data available).
  logic    s1_valid;
  gate_t   s1_gate;
  sample_t s1_sample;
  logic    s1_last;
  logic    s1_full;
  logic    s1_self;
  logic    s1_fwd;
  sample_t s1_fwd_data;

  // Output register.
  logic    out_valid;
  sample_t out_sum;
  logic    out_last;

  logic    cfg_wr;
  logic    acc;
  logic    s1_adv;
  win_t    win_eff;
  logic    full;
  slot_t   cur_slot;
  sample_t s1_base;
  sample_t s1_sum;
  sample_t s1_sub;
  sample_t s1_new;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == REG_WINDOW_LENGTH);
  assign prdata = (paddr == REG_WINDOW_LENGTH) ?
                  PDATA_W'(window_length) : '0;

  assign win_eff  = eff_window(window_length);
  assign full     = (WIN_W'(history_count) + WIN_W'(1)) >= win_eff;
  assign cur_slot = oldest_slot + history_count;

  assign s1_adv    = s1_valid && (!out_valid || dout.ready);
  assign din.ready = !clearing && (!s1_valid || s1_adv);
  assign acc       = din.valid && din.ready;

  // With a window of one the oldest pulse is the current one, so the value
  // taken out is the sample just written.
  assign s1_base = s1_fwd ? s1_fwd_data : gs_rd;
  assign s1_sum  = s1_base + s1_sample;
  assign s1_sub  = s1_self ? s1_sample : hist_rd;
  assign s1_new  = s1_full ? (s1_sum - s1_sub) : s1_sum;

  assign dout.valid      = out_valid;
  assign dout.window_sum = out_sum;
  assign dout.last_out   = out_last;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      gate_index    <= '0;
      history_count <= '0;
      oldest_slot   <= '0;
      clearing      <= 1'b1;
      clr_cnt       <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        window_length <= pwdata[WIN_W-1:0];
        gate_index    <= '0;
        history_count <= '0;
        oldest_slot   <= '0;
        clearing      <= 1'b1;
        clr_cnt       <= '0;
      end else begin
        if (clearing) begin
          clr_cnt <= clr_cnt + GATE_W'(1);
          if (clr_cnt == LAST_GATE) begin
            clearing <= 1'b0;
          end
        end
        if (acc) begin
          if (din.last_in_pulse) begin
            gate_index <= '0;
            if (full) begin
              oldest_slot <= oldest_slot + SLOT_W'(1);
            end else begin
              history_count <= history_count + SLOT_W'(1);
            end
          end else if (gate_index != LAST_GATE) begin
            gate_index <= gate_index + GATE_W'(1);
          end
        end
      end

      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_gate     <= gate_index;
      s1_sample   <= din.sample;
      s1_last     <= din.last_in_pulse;
      s1_full     <= full;
      s1_self     <= full && (history_count == '0);
      // The item leaving stage 1 writes its gate this same edge.
      s1_fwd      <= s1_adv && (s1_gate == gate_index);
      s1_fwd_data <= s1_new;
    end
    if (s1_adv) begin
      out_sum  <= s1_sum;
      out_last <= s1_last;
    end
  end

  // Per-gate running sums: one read at accept, one write from stage 1 or the clear pass.
  always_ff @(posedge clk) begin
    if (clearing) begin
      gs_mem[clr_cnt] <= '0;
    end else if (s1_adv) begin
      gs_mem[s1_gate] <= s1_new;
    end
    if (acc) begin
      gs_rd <= gs_mem[gate_index];
    end
  end

  // Pulse history ring: current sample written, oldest pulse's entry read.
  always_ff @(posedge clk) begin
    if (acc) begin
      hist_mem[{cur_slot, gate_index}] <= din.sample;
      hist_rd <= hist_mem[{oldest_slot, gate_index}];
    end
  end

  `PWS_ASSERT_IMP(a_no_accept_clearing, clearing, !din.ready)
  `PWS_ASSERT_IMP(a_stall_blocks_input, s1_valid && !s1_adv, !acc)
  `PWS_ASSERT_IMP(a_history_below_window, !clearing, WIN_W'(history_count) < win_eff)
  `PWS_ASSERT_NXT(a_last_restarts_gate, acc && din.last_in_pulse && !cfg_wr, gate_index == '0)

endmodule
